FILE: sv/sok_pkg.sv
// Shared constants for the stochastic oscillator percent K unit.
// No dependencies; the result and config interfaces, the divider and the top unit import this package.
package sok_pkg;

  // Width of the window length register and its value after reset
  localparam int unsigned LEN_W = 7;
  localparam logic [LEN_W-1:0] LEN_RESET = 7'd14;

  // Percent K result in unsigned Q7.8, 100 percent is FULL_SCALE
  localparam int unsigned K_W = 15;
  localparam logic [K_W-1:0] FULL_SCALE = 15'd25600;

endpackage

FILE: sv/sok_bar_if.sv
// Input channel carrying one price bar per transaction.
// Depends on nothing but its width parameter.
interface sok_bar_if #(
  parameter int unsigned PRICE_BITS = 32
) ();
  logic                  valid;
  logic                  ready;
  logic [PRICE_BITS-1:0] close_price;
  logic [PRICE_BITS-1:0] low_price;
  logic [PRICE_BITS-1:0] high_price;
  logic                  series_start;

  modport source (output valid, close_price, low_price, high_price, series_start,
                  input ready);
  modport sink   (input valid, close_price, low_price, high_price, series_start,
                  output ready);
endinterface

FILE: sv/sok_result_if.sv
// Output channel carrying one percent K result per transaction.
// Depends on sok_pkg for the result width.
interface sok_result_if import sok_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [K_W-1:0] percent_k;
  logic           warming_up;
  logic           flat_range;
  logic           clipped;

  modport source (output valid, percent_k, warming_up, flat_range, clipped,
                  input ready);
  modport sink   (input valid, percent_k, warming_up, flat_range, clipped,
                  output ready);
endinterface

FILE: sv/sok_cfg_if.sv
// Configuration write channel for the window length register.
// Depends on sok_pkg for the register width.
interface sok_cfg_if import sok_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] window_length;

  modport source (output valid, window_length, input ready);
  modport sink   (input valid, window_length, output ready);
endinterface

FILE: sv/sok_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the high/low bar ring.
module sok_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/sok_div.sv
// Iterative restoring divider: one quotient bit per cycle, then round half up and clamp to full scale.
// Depends on sok_pkg for the quotient width and full scale value.
module sok_div import sok_pkg::*; #(
  parameter int unsigned PRICE_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [PRICE_BITS+K_W-1:0] num,
  input  logic [PRICE_BITS-1:0]     den,
  output logic                      done,
  output logic [K_W-1:0]            quot
);

  localparam int unsigned NUM_W = PRICE_BITS + K_W;
  localparam int unsigned CNT_W = $clog2(K_W);

  typedef enum logic [2:0] {
    DV_IDLE  = 3'b001,
    DV_STEP  = 3'b010,
    DV_ROUND = 3'b100
  } div_state_t;

  div_state_t            state;
  logic [NUM_W-1:0]      rem;
  logic [NUM_W-1:0]      dsh;
  logic [PRICE_BITS-1:0] den_q;
  logic [K_W-1:0]        q;
  logic [CNT_W-1:0]      cnt;
  logic [NUM_W:0]        trial;
  logic                  rnd;
  logic [K_W-1:0]        q_inc;

  // Trial subtract of the shifted divisor; the top bit is the borrow
  assign trial = {1'b0, rem} - {1'b0, dsh};

  // Round half up: remainder is below the divisor here, so it fits a price word
  assign rnd   = {rem[PRICE_BITS-1:0], 1'b0} >= {1'b0, den_q};
  assign q_inc = q + K_W'(rnd);

  // Sequence the quotient bits from the top down
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DV_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        DV_IDLE: begin
          if (start) begin
            rem   <= num;
            dsh   <= NUM_W'(den) << (K_W - 1);
            den_q <= den;
            q     <= '0;
            cnt   <= CNT_W'(K_W - 1);
            state <= DV_STEP;
          end
        end
        DV_STEP: begin
          if (!trial[NUM_W]) begin
            rem <= trial[NUM_W-1:0];
          end
          q   <= {q[K_W-2:0], ~trial[NUM_W]};
          dsh <= dsh >> 1;
          if (cnt == '0) begin
            state <= DV_ROUND;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        DV_ROUND: begin
          quot  <= (q_inc > FULL_SCALE) ? FULL_SCALE : q_inc;
          done  <= 1'b1;
          state <= DV_IDLE;
        end
        default: state <= DV_IDLE;
      endcase
    end
  end

endmodule

FILE: sv/stochastic_oscillator_k_unit.sv
// Stochastic oscillator percent K: one bar in, one result out, one bar at a time.
// Warm-up bars go straight to ST_FINISH; others walk the ring (not for a window of one), then
// pass ST_CHECK, ST_RANGE, ST_MUL and ST_DIV, cut short on a flat range or clipped close. The
// ring walk reads one stored bar per cycle and the divider takes 15 steps. A new bar can be taken
// the cycle after the result enters the output register, which holds while the sink stalls.
// Reset clears sequencer, slot pointer and bar count, sets window_length to 14; ring not cleared.
module stochastic_oscillator_k_unit import sok_pkg::*; #(
  parameter int unsigned WINDOW_MAX = 64,
  parameter int unsigned PRICE_BITS = 32
) (
  input  logic           clk,
  input  logic           rst,
  sok_bar_if.sink        bar,
  sok_result_if.source   result,
  sok_cfg_if.sink        cfg
);

  localparam int unsigned AW    = $clog2(WINDOW_MAX);
  localparam int unsigned CW    = $clog2(WINDOW_MAX + 1);
  localparam int unsigned LW    = (CW > LEN_W) ? CW : LEN_W;
  localparam int unsigned PB    = PRICE_BITS;
  localparam int unsigned NUM_W = PB + K_W;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SCAN   = 7'b0000010,
    ST_CHECK  = 7'b0000100,
    ST_RANGE  = 7'b0001000,
    ST_MUL    = 7'b0010000,
    ST_DIV    = 7'b0100000,
    ST_FINISH = 7'b1000000
  } state_t;

  state_t           state;
  logic [LEN_W-1:0] window_length;
  logic [AW-1:0]    write_slot;
  logic [LW-1:0]    bars_seen;
  logic [LW-1:0]    len_eff;
  logic [LW-1:0]    bars_next;
  logic             warm_next;
  logic             accept;

  // Ring walk
  logic [AW-1:0]    rd_ptr;
  logic [LW-1:0]    issue_cnt;
  logic             pend;
  logic             ram_re;
  logic [2*PB-1:0]  ram_rdata;
  logic [PB-1:0]    ring_hi;
  logic [PB-1:0]    ring_lo;

  // Working registers
  logic [PB-1:0]    close_q;
  logic [PB-1:0]    hh;
  logic [PB-1:0]    ll;
  logic [PB-1:0]    den;
  logic [PB-1:0]    diff;
  logic [NUM_W-1:0] num;
  logic [PB:0]      den_d;
  logic [PB:0]      diff_d;
  logic             div_go;
  logic             div_done;
  logic [K_W-1:0]   div_quot;
  logic [K_W-1:0]   kval;
  logic             warm;
  logic             flat;
  logic             clip;

  // Output register
  logic             res_valid;
  logic             res_load;
  logic [K_W-1:0]   res_k;
  logic             res_warm;
  logic             res_flat;
  logic             res_clip;

  // Take configuration only between bars; a pending write holds off the next bar
  assign cfg.ready         = (state == ST_IDLE);
  assign bar.ready         = (state == ST_IDLE) && !cfg.valid;
  assign accept            = bar.valid && bar.ready;
  assign result.valid      = res_valid;
  assign result.percent_k  = res_k;
  assign result.warming_up = res_warm;
  assign result.flat_range = res_flat;
  assign result.clipped    = res_clip;
  assign res_load          = (state == ST_FINISH) && (!res_valid || result.ready);

  // Clamp the window length to 1..WINDOW_MAX
  always_comb begin
    if (window_length == '0) begin
      len_eff = LW'(1);
    end else if (LW'(window_length) > LW'(WINDOW_MAX)) begin
      len_eff = LW'(WINDOW_MAX);
    end else begin
      len_eff = LW'(window_length);
    end
  end

  // Count this bar, restarting on series start, saturating at the ring depth
  always_comb begin
    bars_next = bar.series_start ? '0 : bars_seen;
    if (bars_next < LW'(WINDOW_MAX)) begin
      bars_next = bars_next + 1'b1;
    end
    warm_next = bars_next < len_eff;
  end

  assign ram_re  = (state == ST_SCAN) && (issue_cnt != '0);
  assign ring_hi = ram_rdata[2*PB-1:PB];
  assign ring_lo = ram_rdata[PB-1:0];

  // Range and close offsets; the top bit is the borrow
  assign den_d  = {1'b0, hh} - {1'b0, ll};
  assign diff_d = {1'b0, close_q} - {1'b0, ll};

  sok_ram #(
    .WIDTH (2 * PB),
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk   (clk),
    .we    (accept),
    .waddr (write_slot),
    .wdata ({bar.high_price, bar.low_price}),
    .re    (ram_re),
    .raddr (rd_ptr),
    .rdata (ram_rdata)
  );

  sok_div #(
    .PRICE_BITS (PB)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_go),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Configuration register; any write restarts the bar count
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= LEN_RESET;
    end else if (cfg.valid && cfg.ready) begin
      window_length <= cfg.window_length;
    end
  end

  // Main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      write_slot <= '0;
      bars_seen  <= '0;
      pend       <= 1'b0;
      div_go     <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      div_go <= 1'b0;
      pend   <= ram_re;

      // Load the output register at the end of a bar, drop it once the sink takes it
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        res_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (cfg.valid && cfg.ready) begin
            // A window length write restarts the series
            bars_seen <= '0;
          end else if (accept) begin
            write_slot <= (write_slot == AW'(WINDOW_MAX - 1)) ? '0 : write_slot + 1'b1;
            bars_seen  <= bars_next;
            close_q    <= bar.close_price;
            hh         <= bar.high_price;
            ll         <= bar.low_price;
            warm       <= warm_next;
            flat       <= 1'b0;
            clip       <= 1'b0;
            kval       <= '0;
            rd_ptr     <= (write_slot == '0) ? AW'(WINDOW_MAX - 1) : write_slot - 1'b1;
            issue_cnt  <= len_eff - 1'b1;
            if (warm_next) begin
              state <= ST_FINISH;
            end else if (len_eff == LW'(1)) begin
              state <= ST_CHECK;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          // Issue one read per cycle, walking back from the bar before the newest
          if (ram_re) begin
            rd_ptr    <= (rd_ptr == '0) ? AW'(WINDOW_MAX - 1) : rd_ptr - 1'b1;
            issue_cnt <= issue_cnt - 1'b1;
          end
          // Fold in the bar read last cycle
          if (pend) begin
            if (ring_hi > hh) begin
              hh <= ring_hi;
            end
            if (ring_lo < ll) begin
              ll <= ring_lo;
            end
          end
          if ((issue_cnt == '0) && !pend) begin
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          den  <= den_d[PB-1:0];
          diff <= diff_d[PB-1:0];
          if (den_d[PB] || (den_d[PB-1:0] == '0)) begin
            flat  <= 1'b1;
            state <= ST_FINISH;
          end else if (diff_d[PB]) begin
            clip  <= 1'b1;
            state <= ST_FINISH;
          end else begin
            state <= ST_RANGE;
          end
        end
        ST_RANGE: begin
          if (diff > den) begin
            clip  <= 1'b1;
            kval  <= FULL_SCALE;
            state <= ST_FINISH;
          end else begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          num    <= NUM_W'(diff) * NUM_W'(FULL_SCALE);
          div_go <= 1'b1;
          state  <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            kval  <= div_quot;
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          // Fill the output register once it is free
          if (res_load) begin
            res_k    <= kval;
            res_warm <= warm;
            res_flat <= flat;
            res_clip <= clip;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
